// ===== hdl/hker_pkg.sv =====
// Shared types and constants for the key event repeat engine.
// Holds the request opcodes, keycode values, lane and result structs.
// No dependencies; the lane, merge, output buffer and top files import this package.
`timescale 1ns / 1ps

package hker_pkg;

    // Request opcodes carried in s_tuser
    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_POLL   = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    localparam int NUM_SLOTS  = 6;
    localparam int KEY_W      = 8;
    localparam int MOD_W      = 8;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 24;
    localparam int HELD_W     = 14;
    localparam int KEY_BITS_W = 12;
    localparam int COUNT_W    = 4;
    localparam int EVENT_W    = KEY_W + MOD_W;

    // Stream widths: input report and output result
    localparam int IN_KEY_LSB = TIME_W + MOD_W;
    localparam int IN_DATA_W  = IN_KEY_LSB + NUM_SLOTS * KEY_W;
    localparam int OUT_USED_W = KEY_W + MOD_W + COUNT_W + HELD_W + 1;
    localparam int OUT_DATA_W = 40;

    // Configuration register indexes
    localparam logic [0:0] REG_REPEAT_DELAY    = 1'b0;
    localparam logic [0:0] REG_REPEAT_INTERVAL = 1'b1;

    localparam logic [CFG_W-1:0] DELAY_RESET    = 24'd400000;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 24'd80000;

    // Modifier byte masks (left and right keys together)
    localparam logic [MOD_W-1:0] MOD_CTRL_MASK  = 8'h11;
    localparam logic [MOD_W-1:0] MOD_SHIFT_MASK = 8'h22;

    // Usage IDs of the tracked keys
    localparam logic [KEY_W-1:0] KC_A      = 8'h04;
    localparam logic [KEY_W-1:0] KC_D      = 8'h07;
    localparam logic [KEY_W-1:0] KC_E      = 8'h08;
    localparam logic [KEY_W-1:0] KC_Q      = 8'h14;
    localparam logic [KEY_W-1:0] KC_S      = 8'h16;
    localparam logic [KEY_W-1:0] KC_W      = 8'h1A;
    localparam logic [KEY_W-1:0] KC_UP     = 8'h52;
    localparam logic [KEY_W-1:0] KC_DOWN   = 8'h51;
    localparam logic [KEY_W-1:0] KC_LEFT   = 8'h50;
    localparam logic [KEY_W-1:0] KC_RIGHT  = 8'h4F;
    localparam logic [KEY_W-1:0] KC_SPACE  = 8'h2C;
    localparam logic [KEY_W-1:0] KC_ESCAPE = 8'h29;

    // Output buffer geometry
    localparam int OBUF_DEPTH = 3;
    localparam int OBUF_PTR_W = 2;

    typedef logic [KEY_W-1:0] key_t;

    // What one slot lane found
    typedef struct packed {
        logic                  is_new;
        logic                  rep_match;
        logic [KEY_BITS_W-1:0] key_bits;
    } lane_t;

    // Combined view of all lanes
    typedef struct packed {
        logic                  found;
        key_t                  fresh_key;
        logic                  rep_match;
        logic [KEY_BITS_W-1:0] key_bits;
    } merge_t;

    // One result item
    typedef struct packed {
        logic               event_valid;
        key_t               event_keycode;
        logic [MOD_W-1:0]   event_modifier;
        logic [COUNT_W-1:0] queued_count;
        logic [HELD_W-1:0]  held_keys;
        logic               dropped;
    } result_t;

endpackage

// ===== hdl/hker_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the event queue banks. No dependencies.
`timescale 1ns / 1ps

module hker_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/hker_lane.sv =====
// One keycode slot lane: new-key test, repeat-key match and held-key decode.
// Depends on hker_pkg.
`timescale 1ns / 1ps

module hker_lane
    import hker_pkg::*;
(
    input  key_t  key,
    input  key_t  prev_keys [NUM_SLOTS],
    input  key_t  rep_key,
    output lane_t result
);

    logic in_prev;

    // Look for this slot's key anywhere in the previous report
    always_comb
    begin
        in_prev = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (prev_keys[i] == key)
            begin
                in_prev = 1'b1;
            end
        end
    end

    // Decode tracked keys into held-key bits
    always_comb
    begin
        result.is_new    = (key != '0) && !in_prev;
        result.rep_match = (key == rep_key);
        result.key_bits  = '0;
        case (key)
            KC_A:      result.key_bits[0]  = 1'b1;
            KC_D:      result.key_bits[1]  = 1'b1;
            KC_E:      result.key_bits[2]  = 1'b1;
            KC_Q:      result.key_bits[3]  = 1'b1;
            KC_S:      result.key_bits[4]  = 1'b1;
            KC_W:      result.key_bits[5]  = 1'b1;
            KC_UP:     result.key_bits[6]  = 1'b1;
            KC_DOWN:   result.key_bits[7]  = 1'b1;
            KC_LEFT:   result.key_bits[8]  = 1'b1;
            KC_RIGHT:  result.key_bits[9]  = 1'b1;
            KC_SPACE:  result.key_bits[10] = 1'b1;
            KC_ESCAPE: result.key_bits[11] = 1'b1;
            default:   result.key_bits     = '0;
        endcase
    end

endmodule

// ===== hdl/hker_merge.sv =====
// Merge stage: picks the first new key by slot order and ORs lane flags.
// Depends on hker_pkg.
`timescale 1ns / 1ps

module hker_merge
    import hker_pkg::*;
(
    input  lane_t  lanes [NUM_SLOTS],
    input  key_t   keys  [NUM_SLOTS],
    output merge_t result
);

    // Scan from the last slot down so the lowest new slot wins
    always_comb
    begin
        result.found     = 1'b0;
        result.fresh_key = '0;
        result.rep_match = 1'b0;
        result.key_bits  = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (lanes[i].is_new)
            begin
                result.found     = 1'b1;
                result.fresh_key = keys[i];
            end
            result.rep_match = result.rep_match | lanes[i].rep_match;
            result.key_bits  = result.key_bits | lanes[i].key_bits;
        end
    end

endmodule

// ===== hdl/hker_out_buf.sv =====
// Three-entry result buffer between the engine pipeline and the output stream.
// Depends on hker_pkg.
`timescale 1ns / 1ps

module hker_out_buf
    import hker_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t               entry [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OBUF_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OBUF_PTR_W-1:0] cnt_reg, cnt_next;
    logic                  pop;

    function automatic logic [OBUF_PTR_W-1:0] ptr_inc(input logic [OBUF_PTR_W-1:0] p);
        return (p == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_valid = (cnt_reg != '0);
    assign out_data  = entry[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Take a new request only if the one in flight plus it still fit
    assign room = ({1'b0, cnt_reg} + {{OBUF_PTR_W{1'b0}}, in_valid})
                  <= (OBUF_PTR_W + 1)'(OBUF_DEPTH - 1);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = in_valid ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + OBUF_PTR_W'(in_valid) - OBUF_PTR_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            entry[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== hdl/hid_key_event_repeat_engine_top.sv =====
// Top level of the keyboard event repeat engine.
// Depends on hker_pkg, hker_lane, hker_merge, hker_ram and hker_out_buf.
`timescale 1ns / 1ps

// The engine accepts one request per clock while s_tready shows room in the output
// buffer, and returns exactly one result per request, in order. One stage covers
// the registered read of the event queue banks, the second is a
// three-entry output buffer that lets the input keep flowing while a result
// waits. A report is checked by six slot lanes side by side (one per keycode
// slot), and their findings are merged before the queue and repeat timer update
// in the same cycle. The event store needs no clearing pass after reset; entries
// are read only after they were written. The queue holds QUEUE_DEPTH-1 events.
// Configuration writes are taken in any cycle but must only be issued while the
// engine is idle.
module hid_key_event_repeat_engine_top
    import hker_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: now_us[31:0], modifier_bits[39:32], key_code_0[47:40] ..
    //          key_code_5[87:80]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: operation[1:0]
    input  logic [1:0]            s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: event_keycode[7:0], event_modifier[15:8], queued_count[19:16],
    //          held_keys[33:20], dropped[34], zero pad[39:35]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // m_tuser: event_valid[0]
    output logic [0:0]            m_tuser
);

    localparam int QW         = $clog2(QUEUE_DEPTH);
    localparam int BANK_DEPTH = QUEUE_DEPTH / 2;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CNT_W      = QW + 1;
    localparam logic [QW-1:0] LAST_IDX = QW'(QUEUE_DEPTH - 1);

    typedef logic [QW-1:0] qidx_t;

    function automatic qidx_t qinc(input qidx_t p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [BAW-1:0] bank_addr(input qidx_t p);
        qidx_t sh;
        sh = p >> 1;
        return sh[BAW-1:0];
    endfunction

    // Request fields
    op_t              in_op;
    logic [TIME_W-1:0] now;
    logic [MOD_W-1:0] in_mod;
    key_t             in_keys  [NUM_SLOTS];
    key_t             eff_keys [NUM_SLOTS];
    logic [MOD_W-1:0] eff_mod;
    logic             acc;

    // Engine state
    key_t              prev_keys_reg [NUM_SLOTS];
    key_t              prev_keys_next [NUM_SLOTS];
    logic [MOD_W-1:0]  prev_mod_reg, prev_mod_next;
    key_t              rep_key_reg, rep_key_next;
    logic [MOD_W-1:0]  rep_mod_reg, rep_mod_next;
    logic [TIME_W-1:0] rep_start_reg, rep_start_next;
    logic [TIME_W-1:0] rep_last_reg, rep_last_next;
    qidx_t             head_reg, head_next;
    qidx_t             tail_reg, tail_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [CFG_W-1:0]  delay_reg;
    logic [CFG_W-1:0]  interval_reg;
    logic [EVENT_W-1:0] last_entry_reg;
    qidx_t             head_plus1;

    // Lane and merge results
    lane_t  lane_res [NUM_SLOTS];
    merge_t merged;

    // Queue write and read controls
    logic               push0_en, push1_en;
    qidx_t              push0_idx, push1_idx;
    logic [EVENT_W-1:0] push0_data, push1_data;
    logic               drop;
    logic               rd_go;
    logic               bank_we    [2];
    logic [BAW-1:0]     bank_waddr [2];
    logic [EVENT_W-1:0] bank_wdata [2];
    logic [EVENT_W-1:0] bank_rdata [2];
    logic               last_we;
    logic [EVENT_W-1:0] last_wdata;
    logic [CNT_W-1:0]   count_after;

    // First pipeline stage
    logic               s1_valid_reg;
    logic               s1_event_valid_reg;
    logic               s1_from_last_reg;
    logic               s1_bank_reg;
    logic [EVENT_W-1:0] s1_last_data_reg;
    logic [COUNT_W-1:0] s1_count_reg;
    logic [HELD_W-1:0]  s1_held_reg;
    logic               s1_dropped_reg;
    logic [EVENT_W-1:0] s1_event;
    result_t            s1_result;
    result_t            out_res;

    // Unpack request
    always_comb
    begin
        in_op  = op_t'(s_tuser);
        now    = s_tdata[TIME_W-1:0];
        in_mod = s_tdata[IN_KEY_LSB-1:TIME_W];
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            in_keys[i]  = s_tdata[IN_KEY_LSB + KEY_W * i +: KEY_W];
            eff_keys[i] = (in_op == OP_REPORT) ? in_keys[i] : prev_keys_reg[i];
        end
        eff_mod = (in_op == OP_REPORT) ? in_mod : prev_mod_reg;
    end

    assign acc        = s_tvalid && s_tready;
    assign head_plus1 = qinc(head_reg);

    // One lane per keycode slot
    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_lane
        hker_lane u_lane (
            .key       (eff_keys[g]),
            .prev_keys (prev_keys_reg),
            .rep_key   (rep_key_reg),
            .result    (lane_res[g])
        );
    end

    hker_merge u_merge (
        .lanes  (lane_res),
        .keys   (eff_keys),
        .result (merged)
    );

    // Queue, repeat timer and held-key update for one request
    always_comb
    begin
        prev_keys_next = prev_keys_reg;
        prev_mod_next  = prev_mod_reg;
        rep_key_next   = rep_key_reg;
        rep_mod_next   = rep_mod_reg;
        rep_start_next = rep_start_reg;
        rep_last_next  = rep_last_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        held_next      = held_reg;
        push0_en       = 1'b0;
        push1_en       = 1'b0;
        push0_idx      = head_reg;
        push1_idx      = head_reg;
        push0_data     = {in_mod, merged.fresh_key};
        push1_data     = '0;
        drop           = 1'b0;
        rd_go          = 1'b0;
        case (in_op)
            OP_REPORT, OP_POLL:
            begin
                // Queue the first newly pressed key and make it the repeat key
                if ((in_op == OP_REPORT) && merged.found)
                begin
                    if (qinc(head_next) != tail_reg)
                    begin
                        push0_en  = 1'b1;
                        push0_idx = head_next;
                        head_next = qinc(head_next);
                    end
                    else
                    begin
                        drop = 1'b1;
                    end
                    rep_key_next   = merged.fresh_key;
                    rep_mod_next   = in_mod;
                    rep_start_next = now;
                    rep_last_next  = now;
                end
                if (in_op == OP_REPORT)
                begin
                    prev_keys_next = in_keys;
                    prev_mod_next  = in_mod;
                end
                held_next = {merged.key_bits,
                             |(eff_mod & MOD_CTRL_MASK),
                             |(eff_mod & MOD_SHIFT_MASK)};
                // Run typematic repeat on the current report
                if (rep_key_next != '0)
                begin
                    if (!(((in_op == OP_REPORT) && merged.found) || merged.rep_match))
                    begin
                        rep_key_next   = '0;
                        rep_mod_next   = '0;
                        rep_start_next = '0;
                        rep_last_next  = '0;
                    end
                    else
                    begin
                        if (eff_mod != rep_mod_next)
                        begin
                            rep_mod_next   = eff_mod;
                            rep_start_next = now;
                            rep_last_next  = now;
                        end
                        if (((now - rep_start_next) >= {8'd0, delay_reg}) &&
                            ((now - rep_last_next) >= {8'd0, interval_reg}))
                        begin
                            if (qinc(head_next) != tail_reg)
                            begin
                                push1_en      = 1'b1;
                                push1_idx     = head_next;
                                push1_data    = {rep_mod_next, rep_key_next};
                                head_next     = qinc(head_next);
                                rep_last_next = now;
                            end
                            else
                            begin
                                drop = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_READ:
            begin
                // Dequeue the oldest event if any
                if (head_reg != tail_reg)
                begin
                    rd_go     = 1'b1;
                    tail_next = qinc(tail_reg);
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    prev_keys_next[i] = '0;
                end
                prev_mod_next  = '0;
                rep_key_next   = '0;
                rep_mod_next   = '0;
                rep_start_next = '0;
                rep_last_next  = '0;
                head_next      = '0;
                tail_next      = '0;
                held_next      = '0;
            end
            default:
            begin
                drop = 1'b0;
            end
        endcase
    end

    // Queue occupancy after this request
    always_comb
    begin
        if (head_next >= tail_next)
        begin
            count_after = CNT_W'(head_next) - CNT_W'(tail_next);
        end
        else
        begin
            count_after = CNT_W'(head_next) + CNT_W'(QUEUE_DEPTH) - CNT_W'(tail_next);
        end
    end

    // Route pushes: even and odd slots go to two banks, the last slot to a register
    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            bank_we[b]    = 1'b0;
            bank_waddr[b] = bank_addr(push0_idx);
            bank_wdata[b] = push0_data;
            if (push0_en && (push0_idx != LAST_IDX) && (push0_idx[0] == 1'(b)))
            begin
                bank_we[b] = acc;
            end
            else if (push1_en && (push1_idx != LAST_IDX) && (push1_idx[0] == 1'(b)))
            begin
                bank_we[b]    = acc;
                bank_waddr[b] = bank_addr(push1_idx);
                bank_wdata[b] = push1_data;
            end
        end
        last_we    = 1'b0;
        last_wdata = push0_data;
        if (push0_en && (push0_idx == LAST_IDX))
        begin
            last_we = acc;
        end
        else if (push1_en && (push1_idx == LAST_IDX))
        begin
            last_we    = acc;
            last_wdata = push1_data;
        end
    end

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        hker_ram #(
            .WIDTH (EVENT_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk     (clk),
            .wr_en   (bank_we[b]),
            .wr_addr (bank_waddr[b]),
            .wr_data (bank_wdata[b]),
            .rd_en   (acc && rd_go),
            .rd_addr (bank_addr(tail_reg)),
            .rd_data (bank_rdata[b])
        );
    end

    // Hold state and first-stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                prev_keys_reg[i] <= '0;
            end
            prev_mod_reg  <= '0;
            rep_key_reg   <= '0;
            rep_mod_reg   <= '0;
            rep_start_reg <= '0;
            rep_last_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            delay_reg     <= DELAY_RESET;
            interval_reg  <= INTERVAL_RESET;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
            if (acc)
            begin
                prev_keys_reg <= prev_keys_next;
                prev_mod_reg  <= prev_mod_next;
                rep_key_reg   <= rep_key_next;
                rep_mod_reg   <= rep_mod_next;
                rep_start_reg <= rep_start_next;
                rep_last_reg  <= rep_last_next;
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                held_reg      <= held_next;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_REPEAT_DELAY:    delay_reg    <= cfg_data;
                    REG_REPEAT_INTERVAL: interval_reg <= cfg_data;
                    default:             delay_reg    <= delay_reg;
                endcase
            end
        end
    end

    // Hold payload: last queue slot and first-stage result fields
    always_ff @(posedge clk)
    begin
        if (last_we)
        begin
            last_entry_reg <= last_wdata;
        end
        if (acc)
        begin
            s1_event_valid_reg <= rd_go;
            s1_from_last_reg   <= (tail_reg == LAST_IDX);
            s1_bank_reg        <= tail_reg[0];
            s1_last_data_reg   <= last_entry_reg;
            s1_count_reg       <= COUNT_W'(count_after);
            s1_held_reg        <= held_next;
            s1_dropped_reg     <= drop;
        end
    end

    // Pick the dequeued event from its bank or the last-slot register
    always_comb
    begin
        if (!s1_event_valid_reg)
        begin
            s1_event = '0;
        end
        else if (s1_from_last_reg)
        begin
            s1_event = s1_last_data_reg;
        end
        else
        begin
            s1_event = s1_bank_reg ? bank_rdata[1] : bank_rdata[0];
        end
        s1_result.event_valid    = s1_event_valid_reg;
        s1_result.event_keycode  = s1_event[KEY_W-1:0];
        s1_result.event_modifier = s1_event[EVENT_W-1:KEY_W];
        s1_result.queued_count   = s1_count_reg;
        s1_result.held_keys      = s1_held_reg;
        s1_result.dropped        = s1_dropped_reg;
    end

    hker_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_data   (s1_result),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {(OUT_DATA_W - OUT_USED_W)'(0), out_res.dropped, out_res.held_keys,
                      out_res.queued_count, out_res.event_modifier, out_res.event_keycode};
    assign m_tuser = out_res.event_valid;

    // A drop leaves the queue full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_dropped_reg) |-> (head_plus1 == tail_reg))
        else $error("drop reported while queue not full");

    // A read of a non-empty queue advances the read pointer
    a_read_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (in_op == OP_READ) && (head_reg != tail_reg)) |=>
        (tail_reg != $past(tail_reg)))
        else $error("read did not advance queue tail");

    // Clear empties the queue and drops repeat and held state
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (in_op == OP_CLEAR)) |=>
        ((head_reg == tail_reg) && (held_reg == '0) && (rep_key_reg == '0)))
        else $error("clear left state behind");

    // No repeat key means the repeat timer is at rest
    a_idle_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (rep_key_reg == '0) |->
        ((rep_mod_reg == '0) && (rep_start_reg == '0) && (rep_last_reg == '0)))
        else $error("repeat state active without a repeat key");

endmodule
